/* design/dcte_pkg.sv */
// Package: types, widths and calendar tables for the date-to-epoch block.
`timescale 1ns / 1ps
`default_nettype none

package dcte_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    localparam int SECS_W  = 32;
    localparam int DAYS_W  = 20;   // day count up to year 4095 fits in 20 bits

    localparam logic [YEAR_W-1:0]  EPOCH_YEAR   = 12'd1970;
    localparam logic [16:0]        SECS_PER_DAY = 17'(1440 * 60);
    localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;
    localparam logic [9:0]         LEAPS_BEFORE_EPOCH = 10'd477;   // leaps in 1..1969
    localparam logic [10:0]        RECIP_25 = 11'd1311;            // 2^15 / 25, rounded up
    localparam int                 RECIP_SHIFT = 15;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    typedef struct packed {
        logic [DAY_W-1:0]   day_of_month;
        logic [MONTH_W-1:0] month_number;
        logic [YEAR_W-1:0]  year_number;
    } t_date_in;

    typedef struct packed {
        logic              date_valid;
        logic [SECS_W-1:0] epoch_seconds;
    } t_date_out;

    typedef struct packed {
        logic              ok;
        logic [DAYS_W-1:0] days;
    } t_day_count;

    // Days in a common year's month.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in a common year before the first of the month.
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        unique case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* design/dcte_days.sv */
// Date validation and day count since 1970-01-01 (combinational).
`timescale 1ns / 1ps
`default_nettype none

module dcte_days (
    input  wire dcte_pkg::t_date_in   i_date,
    output dcte_pkg::t_day_count      o_count
);

    logic [dcte_pkg::DAY_W-1:0]   day;
    logic [dcte_pkg::MONTH_W-1:0] mon;
    logic [dcte_pkg::YEAR_W-1:0]  year;

    logic [22:0]  y_prod;
    logic [7:0]   y_div25;
    logic [11:0]  y_rem25;
    logic         is_leap;
    logic [4:0]   len;
    logic         mon_ok;
    logic         day_ok;

    logic [11:0]  ym1;
    logic [9:0]   ym1_div4;
    logic [20:0]  q_prod;
    logic [5:0]   ym1_div100;
    logic [18:0]  c_prod;
    logic [3:0]   ym1_div400;
    logic [9:0]   nleaps;
    logic [11:0]  nyears;
    logic [19:0]  year_days;
    logic [19:0]  days;

    assign day  = i_date.day_of_month;
    assign mon  = i_date.month_number;
    assign year = i_date.year_number;

    // year / 25 by reciprocal; exact for 12-bit years
    assign y_prod  = 23'(year) * 23'(dcte_pkg::RECIP_25);
    assign y_div25 = y_prod[dcte_pkg::RECIP_SHIFT +: 8];
    assign y_rem25 = year - 12'(y_div25) * 12'd25;
    assign is_leap = (year[1:0] == 2'd0) && ((y_rem25 != 12'd0) || (year[3:0] == 4'd0));

    assign mon_ok = (mon >= dcte_pkg::MON_JAN) && (mon <= dcte_pkg::MON_DEC);
    assign len    = dcte_pkg::month_len(mon) + 5'((mon == dcte_pkg::MON_FEB) && is_leap);
    assign day_ok = (day != 5'd0) && (day <= len);

    // leaps in 1970..year-1 = L(year-1) - L(1969)
    assign ym1        = year - 12'd1;
    assign ym1_div4   = ym1[11:2];
    assign q_prod     = 21'(ym1_div4) * 21'(dcte_pkg::RECIP_25);
    assign ym1_div100 = q_prod[dcte_pkg::RECIP_SHIFT +: 6];
    assign c_prod     = 19'(ym1[11:4]) * 19'(dcte_pkg::RECIP_25);
    assign ym1_div400 = c_prod[dcte_pkg::RECIP_SHIFT +: 4];
    assign nleaps     = ym1_div4 - 10'(ym1_div100) + 10'(ym1_div400)
                      - dcte_pkg::LEAPS_BEFORE_EPOCH;
    assign nyears     = year - dcte_pkg::EPOCH_YEAR;

    always_comb begin
        if (year > dcte_pkg::EPOCH_YEAR) begin
            year_days = 20'(nyears) * 20'(dcte_pkg::DAYS_PER_YEAR) + 20'(nleaps);
        end else begin
            year_days = 20'd0;
        end
    end

    assign days = year_days
                + 20'(dcte_pkg::days_before_month(mon))
                + 20'((mon > dcte_pkg::MON_FEB) && is_leap)
                + 20'(day) - 20'd1;

    assign o_count.ok   = mon_ok && day_ok;
    assign o_count.days = days;

endmodule

`default_nettype wire

/* design/date_check_to_epoch_seconds.sv */
// Top level: Gregorian date check and conversion to seconds since 1970.
//
// One date is taken per clock while start is high; busy never rises. The
// result appears on o_result with o_done high for one cycle; the date passes
// through the input register, the day-count register (date check, leap count,
// month table), then the days-times-86400 multiply into the result register.
// The receiver cannot stall; every result must be taken.
`timescale 1ns / 1ps
`default_nettype none

module date_check_to_epoch_seconds (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       start,
    output logic                      busy,
    input  wire dcte_pkg::t_date_in   i_date,
    output logic                      o_done,
    output dcte_pkg::t_date_out       o_result
);

    logic                    r_in_vld;
    dcte_pkg::t_date_in      r_in;
    logic                    r_cnt_vld;
    dcte_pkg::t_day_count    r_cnt;
    dcte_pkg::t_day_count    n_cnt;
    logic                    r_out_vld;
    dcte_pkg::t_date_out     r_out;
    dcte_pkg::t_date_out     n_out;
    logic [36:0]             secs_full;

    assign busy = 1'b0;

    dcte_days u_days (
        .i_date  (r_in),
        .o_count (n_cnt)
    );

    assign secs_full = 37'(r_cnt.days) * 37'(dcte_pkg::SECS_PER_DAY);

    always_comb begin
        n_out.date_valid    = r_cnt.ok;
        n_out.epoch_seconds = r_cnt.ok ? secs_full[dcte_pkg::SECS_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_cnt_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_cnt_vld <= r_in_vld;
            r_out_vld <= r_cnt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_date;
        end
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    assign o_done   = r_out_vld;
    assign o_result = r_out;

endmodule

`default_nettype wire

/* design/dcte_checker.sv */
// Port-level checker for the date-to-epoch block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module dcte_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       start,
    input wire                       busy,
    input wire dcte_pkg::t_date_in   i_date,
    input wire                       o_done,
    input wire dcte_pkg::t_date_out  o_result
);

    a_busy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##3 o_done)
        else $error("accepted beat produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 3))
        else $error("result without an accepted beat");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.date_valid) |-> (o_result.epoch_seconds == 32'd0))
        else $error("invalid date gave nonzero seconds");

    a_bad_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && (i_date.month_number == 4'd0 || i_date.month_number > 4'd12))
            |-> ##3 (o_done && !o_result.date_valid))
        else $error("bad month reported valid");

endmodule

bind date_check_to_epoch_seconds dcte_checker u_dcte_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_date   (i_date),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire

/* sim/date_epoch_checker.sv */
`timescale 1ns / 1ps
// Checker: predicts the epoch seconds of each accepted date and compares the result beats.
module date_epoch_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_busy,
    input  dcte_pkg::t_date_in  i_date,
    input  wire                 i_done,
    input  dcte_pkg::t_date_out i_result,
    output int                  o_fail_count,
    output int                  o_pending
);
    import dcte_pkg::*;

    localparam int REPORT_LIMIT = 10;

    t_date_out expected_epochs[$];
    int        fail_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic bit is_leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 25 != 0) || (y % 16 == 0));
    endfunction

    // Leap years in 1..n.
    function automatic int unsigned leaps_through(input int unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input bit leap_yr);
        int unsigned len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = leap_yr ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic t_date_out predict_epoch(input t_date_in d);
        t_date_out         r;
        int unsigned       y;
        int unsigned       m;
        int unsigned       dd;
        int unsigned       epoch_yr;
        bit                leap_yr;
        longint unsigned   days;
        int unsigned       i;
        r        = '0;
        y        = d.year_number;
        m        = d.month_number;
        dd       = d.day_of_month;
        epoch_yr = EPOCH_YEAR;
        leap_yr  = is_leap_year(y);
        if (m >= 1 && m <= 12 && dd != 0 && dd <= days_in_month(m, leap_yr)) begin
            days = 0;
            if (y > epoch_yr) begin
                days = longint'(y - epoch_yr) * DAYS_PER_YEAR
                     + leaps_through(y - 1) - leaps_through(epoch_yr - 1);
            end
            for (i = 1; i < m; i++) begin
                days += days_in_month(i, leap_yr);
            end
            days += dd - 1;
            r.date_valid    = 1'b1;
            r.epoch_seconds = 32'(days * SECS_PER_DAY);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_date_out want;
        if (!i_rst_n) begin
            expected_epochs.delete();
        end else begin
            if (i_done) begin
                if (expected_epochs.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t: unexpected result beat: valid=%0b secs=%0d",
                                 $time, i_result.date_valid, i_result.epoch_seconds);
                    fail_count++;
                end else begin
                    want = expected_epochs.pop_front();
                    if (i_result.date_valid !== want.date_valid ||
                        i_result.epoch_seconds !== want.epoch_seconds) begin
                        if (fail_count < REPORT_LIMIT)
                            $display("%0t: mismatch: expected valid=%0b secs=%0d, got valid=%0b secs=%0d",
                                     $time, want.date_valid, want.epoch_seconds,
                                     i_result.date_valid, i_result.epoch_seconds);
                        fail_count++;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_epochs.push_back(predict_epoch(i_date));
        end
        o_fail_count = fail_count;
        o_pending    = expected_epochs.size();
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Testbench top: drives directed and random dates into the converter and reports the verdict.
module testbench;
    import dcte_pkg::*;

    localparam int RANDOM_ITEMS = 1450;
    localparam int PHASES       = 4;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_LIMIT  = 1000;
    localparam int LATENCY      = 3;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_date_in  i_date;
    logic      o_done;
    t_date_out o_result;
    int        fail_count;
    int        pending;

    date_check_to_epoch_seconds dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_date   (i_date),
        .o_done   (o_done),
        .o_result (o_result)
    );

    date_epoch_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_date       (i_date),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_date_in make_date(input int d, input int m, input int y);
        t_date_in r;
        r.day_of_month = 5'(d);
        r.month_number = 4'(m);
        r.year_number  = 12'(y);
        return r;
    endfunction

    // Mostly in-range months, some month-end days and century years; the rest raw noise.
    function automatic t_date_in random_date();
        t_date_in    d;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            d.day_of_month = 5'($urandom);
            d.month_number = 4'($urandom);
            d.year_number  = 12'($urandom);
        end else begin
            d.month_number = 4'($urandom_range(1, 12));
            if ($urandom_range(0, 9) < 7)
                d.day_of_month = 5'($urandom_range(1, 28));
            else
                d.day_of_month = 5'($urandom_range(28, 31));
            pick = $urandom_range(0, 99);
            if (pick < 55)
                d.year_number = 12'($urandom_range(1900, 2200));
            else if (pick < 70)
                d.year_number = 12'(100 * $urandom_range(0, 40));
            else if (pick < 80)
                d.year_number = 12'($urandom_range(0, 1969));
            else
                d.year_number = 12'($urandom_range(0, 4095));
        end
        return d;
    endfunction

    task automatic send_date(input t_date_in d);
        @(negedge i_clk);
        start  = 1'b1;
        i_date = d;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic idle_beat();
        @(negedge i_clk);
        start  = 1'b0;
        i_date = random_date();
    endtask

    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n && ((start && !busy) || o_done))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int n;
        int idle_pct;
        int drain_cycles;
        start   = 1'b0;
        i_date  = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_date(make_date(1, 1, 1970));
        send_date(make_date(2, 1, 1970));
        send_date(make_date(31, 12, 1969));
        send_date(make_date(0, 1, 2000));
        send_date(make_date(31, 15, 4095));
        send_date(make_date(1, 0, 2000));
        send_date(make_date(1, 13, 2000));
        send_date(make_date(29, 2, 2000));
        send_date(make_date(29, 2, 1900));
        send_date(make_date(29, 2, 2024));
        send_date(make_date(29, 2, 2023));
        send_date(make_date(28, 2, 2023));
        send_date(make_date(29, 2, 0));
        send_date(make_date(31, 12, 0));
        send_date(make_date(29, 2, 2100));
        send_date(make_date(29, 2, 2400));
        send_date(make_date(31, 4, 2021));
        send_date(make_date(30, 4, 2021));
        send_date(make_date(1, 3, 2000));
        send_date(make_date(1, 1, 1971));
        send_date(make_date(19, 1, 2038));
        send_date(make_date(7, 2, 2106));
        send_date(make_date(31, 12, 4095));
        send_date(make_date(31, 1, 4095));
        send_date(make_date(30, 2, 2000));

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1:       idle_pct = 63;
                2:       idle_pct = 23;
                default: idle_pct = 0;
            endcase
            for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                while ($urandom_range(0, 99) < idle_pct) idle_beat();
                send_date(random_date());
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        drain_cycles = 0;
        while (pending != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        repeat (LATENCY + 5) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
